// File: rtl/core/shpd_pkg.sv
// Shared types, register codes and constants for the ship heading plant derivative core.
package shpd_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_RUDDER_GAIN       = 3'd0,
        REG_YAW_TIME_CONSTANT = 3'd1,
        REG_WAVE_AMPLITUDE    = 3'd2,
        REG_WAVE_FREQUENCY    = 3'd3,
        REG_RUDDER_LIMIT      = 3'd4,
        REG_RUDDER_RATE_LIMIT = 3'd5,
        REG_SERVO_LAG         = 3'd6
    } t_reg_idx;

    // Register reset values
    localparam logic signed [31:0] RST_RUDDER_GAIN       = 32'sd3355443;
    localparam logic [30:0]        RST_YAW_TIME_CONSTANT = 31'd335544320;
    localparam logic signed [31:0] RST_WAVE_AMPLITUDE    = 32'sd33554;
    localparam logic [30:0]        RST_WAVE_FREQUENCY    = 31'd8388608;
    localparam logic [30:0]        RST_RUDDER_LIMIT      = 31'd10249201;
    localparam logic [30:0]        RST_RUDDER_RATE_LIMIT = 31'd879126;
    localparam logic [30:0]        RST_SERVO_LAG         = 31'd33554432;

    // Phase arithmetic: Q.40 product, reduced modulo 2*pi, folded in Q.30
    localparam int               PHASE_W    = 63;
    localparam int               MOD_STEPS  = 21;
    localparam logic [62:0]      TWO_PI_Q40 = 63'h6487ED5110B;
    localparam logic [32:0]      PI_Q30      = 33'h0C90FDAA2;
    localparam logic [32:0]      HALF_PI_Q30 = 33'h06487ED51;

    // Divider widths
    localparam int DEN_W     = 31;
    localparam int YAW_NUM_W = 63;
    localparam int RUD_NUM_W = 56;

    typedef struct packed {
        logic signed [31:0] yaw_rate;
        logic signed [31:0] rudder_angle;
        logic signed [31:0] rudder_command;
        logic [31:0]        sim_time;
    } t_in;

    typedef struct packed {
        logic signed [31:0] heading_rate;
        logic signed [31:0] yaw_accel;
        logic signed [31:0] rudder_rate;
    } t_out;

    typedef struct packed {
        logic signed [31:0] rudder_gain;
        logic [30:0]        yaw_time_constant;
        logic signed [31:0] wave_amplitude;
        logic [30:0]        wave_frequency;
        logic [30:0]        rudder_limit;
        logic [30:0]        rudder_rate_limit;
        logic [30:0]        servo_lag;
    } t_cfg;

endpackage

// File: rtl/core/shpd_cfg.sv
// APB register block holding the plant coefficients.
module shpd_cfg
    import shpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rudder_gain       <= RST_RUDDER_GAIN;
            r_cfg.yaw_time_constant <= RST_YAW_TIME_CONSTANT;
            r_cfg.wave_amplitude    <= RST_WAVE_AMPLITUDE;
            r_cfg.wave_frequency    <= RST_WAVE_FREQUENCY;
            r_cfg.rudder_limit      <= RST_RUDDER_LIMIT;
            r_cfg.rudder_rate_limit <= RST_RUDDER_RATE_LIMIT;
            r_cfg.servo_lag         <= RST_SERVO_LAG;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RUDDER_GAIN:       r_cfg.rudder_gain       <= pwdata;
                REG_YAW_TIME_CONSTANT: r_cfg.yaw_time_constant <= pwdata[30:0];
                REG_WAVE_AMPLITUDE:    r_cfg.wave_amplitude    <= pwdata;
                REG_WAVE_FREQUENCY:    r_cfg.wave_frequency    <= pwdata[30:0];
                REG_RUDDER_LIMIT:      r_cfg.rudder_limit      <= pwdata[30:0];
                REG_RUDDER_RATE_LIMIT: r_cfg.rudder_rate_limit <= pwdata[30:0];
                REG_SERVO_LAG:         r_cfg.servo_lag         <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // read-back
    always_comb begin
        unique case (w_idx)
            REG_RUDDER_GAIN:       prdata = r_cfg.rudder_gain;
            REG_YAW_TIME_CONSTANT: prdata = {1'b0, r_cfg.yaw_time_constant};
            REG_WAVE_AMPLITUDE:    prdata = r_cfg.wave_amplitude;
            REG_WAVE_FREQUENCY:    prdata = {1'b0, r_cfg.wave_frequency};
            REG_RUDDER_LIMIT:      prdata = {1'b0, r_cfg.rudder_limit};
            REG_RUDDER_RATE_LIMIT: prdata = {1'b0, r_cfg.rudder_rate_limit};
            REG_SERVO_LAG:         prdata = {1'b0, r_cfg.servo_lag};
            default:               prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/shpd_delay.sv
// Enabled shift-register delay line used to align pipeline branches.
module shpd_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    if (DEPTH == 0) begin : g_none
        assign o_data = i_data;
    end else begin : g_line
        logic [WIDTH-1:0] r_sr [DEPTH];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sr[0] <= i_data;
                for (int i = 1; i < DEPTH; i++) begin
                    r_sr[i] <= r_sr[i-1];
                end
            end
        end

        assign o_data = r_sr[DEPTH-1];
    end

endmodule

// File: rtl/core/shpd_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned.
module shpd_div #(
    parameter int NUM_W = 63,
    parameter int DEN_W = 31
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quot
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];

    for (genvar gi = 0; gi < NUM_W; gi++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [DEN_W:0]   trial;
        logic             ge;

        if (gi == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = i_num;
        end else begin : g_next
            assign rem_in = r_rem[gi-1];
            assign nq_in  = r_nq[gi-1];
        end

        // shift in the next numerator bit and try the subtraction
        assign trial = {rem_in, nq_in[NUM_W-1]};
        assign ge    = trial >= {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gi] <= ge ? DEN_W'(trial - {1'b0, i_den}) : DEN_W'(trial);
                r_nq[gi]  <= {nq_in[NUM_W-2:0], ge};
            end
        end
    end

    assign o_quot = r_nq[NUM_W-1];

endmodule

// File: rtl/core/shpd_sine.sv
// Pipelined wave phase and Taylor-series sine (magnitude in Q2.30 plus sign).
module shpd_sine
    import shpd_pkg::*;
#(
    parameter int SINE_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_sim_time,
    input  logic [30:0] i_freq,
    output logic [31:0] o_mag,
    output logic        o_neg
);

    typedef struct packed {
        logic [31:0] x2;
        logic [32:0] pos;
        logic [32:0] nsum;
        logic        neg;
    } t_sacc;

    logic [PHASE_W-1:0] r_md [MOD_STEPS+1];
    logic [32:0]        w_x;
    logic [32:0]        w_xa;
    logic [32:0]        w_xb;
    logic               w_neg;
    logic [30:0]        r_fx;
    logic               r_fneg;
    logic [31:0]        r_t0;
    t_sacc              r_acc0;

    logic [32:0] r_an   [1:SINE_STAGES-1];
    t_sacc       r_aacc [1:SINE_STAGES-1];
    logic [30:0] r_bq0  [1:SINE_STAGES-1];
    logic [32:0] r_bn   [1:SINE_STAGES-1];
    t_sacc       r_bacc [1:SINE_STAGES-1];
    logic [31:0] r_cterm[1:SINE_STAGES-1];
    t_sacc       r_cacc [1:SINE_STAGES-1];

    logic [31:0] r_smag;
    logic        r_sneg;

    // phase product, Q.40
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_md[0] <= PHASE_W'(i_freq) * PHASE_W'(i_sim_time);
        end
    end

    // modulo 2*pi, one conditional subtract of a shifted 2*pi per stage
    for (genvar gj = 0; gj < MOD_STEPS; gj++) begin : g_mod
        localparam logic [PHASE_W-1:0] MODC = TWO_PI_Q40 << (MOD_STEPS - 1 - gj);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_md[gj+1] <= (r_md[gj] >= MODC) ? r_md[gj] - MODC : r_md[gj];
            end
        end
    end

    // fold into the first quadrant
    assign w_x   = r_md[MOD_STEPS][42:10];
    assign w_neg = w_x > PI_Q30;
    assign w_xa  = w_neg ? w_x - PI_Q30 : w_x;
    assign w_xb  = (w_xa > HALF_PI_Q30) ? PI_Q30 - w_xa : w_xa;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fx   <= w_xb[30:0];
            r_fneg <= w_neg;
        end
    end

    // x squared and series start
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc0.x2   <= 32'((62'(r_fx) * 62'(r_fx)) >> 30);
            r_acc0.pos  <= {2'b00, r_fx};
            r_acc0.nsum <= '0;
            r_acc0.neg  <= r_fneg;
            r_t0        <= {1'b0, r_fx};
        end
    end

    // series terms, three stages each: product, reciprocal multiply, correction
    for (genvar gk = 1; gk < SINE_STAGES; gk++) begin : g_term
        localparam int          DIV = (2 * gk) * (2 * gk + 1);
        localparam logic [11:0] DV  = 12'(DIV);
        localparam logic [30:0] M   = 31'((64'd1 << 33) / DIV);

        logic [31:0] term_in;
        t_sacc       acc_in;
        logic [42:0] qd;
        logic [32:0] rm;
        logic [31:0] q;

        if (gk == 1) begin : g_first
            assign term_in = r_t0;
            assign acc_in  = r_acc0;
        end else begin : g_next
            assign term_in = r_cterm[gk-1];
            assign acc_in  = r_cacc[gk-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_an[gk]   <= 33'((64'(term_in) * 64'(acc_in.x2)) >> 30);
                r_aacc[gk] <= acc_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_bq0[gk]  <= 31'((64'(r_an[gk]) * 64'(M)) >> 33);
                r_bn[gk]   <= r_an[gk];
                r_bacc[gk] <= r_aacc[gk];
            end
        end

        // reciprocal estimate is at most one short
        assign qd = 43'(r_bq0[gk]) * 43'(DV);
        assign rm = r_bn[gk] - 33'(qd);
        assign q  = 32'(r_bq0[gk]) + ((rm >= 33'(DV)) ? 32'd1 : 32'd0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cterm[gk]     <= q;
                r_cacc[gk].x2   <= r_bacc[gk].x2;
                r_cacc[gk].neg  <= r_bacc[gk].neg;
                if ((gk % 2) == 1) begin
                    r_cacc[gk].pos  <= r_bacc[gk].pos;
                    r_cacc[gk].nsum <= r_bacc[gk].nsum + 33'(q);
                end else begin
                    r_cacc[gk].pos  <= r_bacc[gk].pos + 33'(q);
                    r_cacc[gk].nsum <= r_bacc[gk].nsum;
                end
            end
        end
    end

    // final magnitude
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_smag <= 32'(r_cacc[SINE_STAGES-1].pos - r_cacc[SINE_STAGES-1].nsum);
            r_sneg <= r_cacc[SINE_STAGES-1].neg;
        end
    end

    assign o_mag = r_smag;
    assign o_neg = r_sneg;

endmodule

// File: rtl/core/ship_heading_plant_derivatives_core.sv
// Output timing is set by the sine series pipeline or the 63-stage yaw divider, whichever is longer.
// Throughput: one item per cycle; a two-entry output buffer keeps the pipeline moving
// while one result waits. The pipeline halts only when that buffer is full and stalled.
// Reset: synchronous active-low; clears valid bits, empties the output buffer, loads config reset values.
module ship_heading_plant_derivatives_core
    import shpd_pkg::*;
#(
    parameter int DATA_WIDTH  = 32,
    parameter int SINE_STAGES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in                   i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out                  o_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int LAT_SINE  = 25 + 3 * (SINE_STAGES - 1);
    localparam int LAT_WAVE  = LAT_SINE + 1;
    localparam int LAT_YAW   = 2 + YAW_NUM_W;
    localparam int LAT_RUD   = 2 + RUD_NUM_W;
    localparam int LAT_ALIGN = (LAT_WAVE > LAT_YAW) ? LAT_WAVE : LAT_YAW;
    localparam int LAT_LAST  = LAT_ALIGN + 1;
    localparam logic signed [64:0] SAT_HI = (65'sd1 <<< (DATA_WIDTH - 1)) - 65'sd1;
    localparam logic signed [64:0] SAT_LO = -SAT_HI - 65'sd1;

    t_cfg w_cfg;
    logic w_adv;

    logic [LAT_LAST:0] r_vld;
    t_in               r_in;

    logic signed [31:0] w_gain;
    logic signed [31:0] w_delta0;
    logic signed [32:0] w_u;
    logic signed [32:0] w_lim;
    logic signed [31:0] w_cmd;

    logic signed [63:0] r_s1_prod;
    logic signed [31:0] r_s1_yaw;
    logic signed [31:0] r_s1_delta;
    logic signed [31:0] r_s1_cmd;

    logic signed [63:0] w_num;
    logic signed [32:0] w_diff;
    logic [62:0]        r_s2_ymag;
    logic               r_s2_yneg;
    logic [31:0]        r_s2_rmag;
    logic               r_s2_rneg;

    logic [DEN_W-1:0]     w_tconst;
    logic [DEN_W-1:0]     w_lag;
    logic [YAW_NUM_W-1:0] w_yq;
    logic [RUD_NUM_W-1:0] w_rq;

    logic [31:0] w_smag;
    logic        w_sneg;
    logic [31:0] w_amag;
    logic [33:0] r_wv_mag;
    logic        r_wv_neg;

    logic [31:0]          w_head_d;
    logic [34:0]          w_wave_d;
    logic [YAW_NUM_W-1:0] w_yq_d;
    logic [RUD_NUM_W-1:0] w_rq_d;
    logic [1:0]           w_sgn_d;

    logic signed [64:0] r_f_quot;
    logic signed [34:0] r_f_wave;
    logic [30:0]        r_f_rmag;
    logic               r_f_rneg;
    logic signed [31:0] r_f_head;

    logic signed [64:0] w_sum;
    logic signed [64:0] w_acc_sat;
    logic signed [64:0] w_rate;
    logic signed [64:0] w_rate_sat;
    t_out               w_out;

    t_out       r_fifo [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    // configuration registers
    shpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // global advance: stop only when the output buffer is full and stalled
    assign w_adv   = !((r_cnt == 2'd2) && i_stall);
    assign o_stall = !w_adv;

    // valid bits and input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT_LAST-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in <= i_data;
        end
    end

    // stage 1: gain product and command clamp
    assign w_gain   = w_cfg.rudder_gain;
    assign w_delta0 = r_in.rudder_angle;
    assign w_u      = 33'(r_in.rudder_command);
    assign w_lim    = {2'b00, w_cfg.rudder_limit};

    always_comb begin
        if (w_u > w_lim) begin
            w_cmd = 32'(w_lim);
        end else if (w_u < -w_lim) begin
            w_cmd = 32'(-w_lim);
        end else begin
            w_cmd = 32'(w_u);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_prod  <= 64'(w_gain) * 64'(w_delta0);
            r_s1_yaw   <= r_in.yaw_rate;
            r_s1_delta <= w_delta0;
            r_s1_cmd   <= w_cmd;
        end
    end

    // stage 2: numerators as magnitude and sign
    assign w_num  = r_s1_prod - (64'(r_s1_yaw) <<< 24);
    assign w_diff = 33'(r_s1_cmd) - 33'(r_s1_delta);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_ymag <= w_num[63] ? 63'(-w_num) : 63'(w_num);
            r_s2_yneg <= w_num[63];
            r_s2_rmag <= w_diff[32] ? 32'(-w_diff) : 32'(w_diff);
            r_s2_rneg <= w_diff[32];
        end
    end

    // zero divisors count as one LSB
    assign w_tconst = (w_cfg.yaw_time_constant == '0) ? DEN_W'(1) : w_cfg.yaw_time_constant;
    assign w_lag    = (w_cfg.servo_lag == '0) ? DEN_W'(1) : w_cfg.servo_lag;

    shpd_div #(.NUM_W(YAW_NUM_W), .DEN_W(DEN_W)) u_div_yaw (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (r_s2_ymag),
        .i_den  (w_tconst),
        .o_quot (w_yq)
    );

    shpd_div #(.NUM_W(RUD_NUM_W), .DEN_W(DEN_W)) u_div_rud (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  ({r_s2_rmag, 24'd0}),
        .i_den  (w_lag),
        .o_quot (w_rq)
    );

    // wave disturbance
    shpd_sine #(.SINE_STAGES(SINE_STAGES)) u_sine (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_sim_time (r_in.sim_time),
        .i_freq     (w_cfg.wave_frequency),
        .o_mag      (w_smag),
        .o_neg      (w_sneg)
    );

    assign w_amag = w_cfg.wave_amplitude[31] ? 32'(-w_cfg.wave_amplitude)
                                             : 32'(w_cfg.wave_amplitude);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_wv_mag <= 34'((64'(w_amag) * 64'(w_smag)) >> 30);
            r_wv_neg <= w_cfg.wave_amplitude[31] ^ w_sneg;
        end
    end

    // align all branches
    shpd_delay #(.WIDTH(32), .DEPTH(LAT_ALIGN)) u_dly_head (
        .i_clk (i_clk), .i_en (w_adv), .i_data (r_in.yaw_rate), .o_data (w_head_d)
    );

    shpd_delay #(.WIDTH(35), .DEPTH(LAT_ALIGN - LAT_WAVE)) u_dly_wave (
        .i_clk (i_clk), .i_en (w_adv), .i_data ({r_wv_neg, r_wv_mag}), .o_data (w_wave_d)
    );

    shpd_delay #(.WIDTH(YAW_NUM_W), .DEPTH(LAT_ALIGN - LAT_YAW)) u_dly_yq (
        .i_clk (i_clk), .i_en (w_adv), .i_data (w_yq), .o_data (w_yq_d)
    );

    shpd_delay #(.WIDTH(RUD_NUM_W), .DEPTH(LAT_ALIGN - LAT_RUD)) u_dly_rq (
        .i_clk (i_clk), .i_en (w_adv), .i_data (w_rq), .o_data (w_rq_d)
    );

    shpd_delay #(.WIDTH(2), .DEPTH(LAT_ALIGN - 2)) u_dly_sgn (
        .i_clk (i_clk), .i_en (w_adv), .i_data ({r_s2_yneg, r_s2_rneg}), .o_data (w_sgn_d)
    );

    // sign restore and rate limit
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_quot <= w_sgn_d[1] ? -65'(w_yq_d) : 65'(w_yq_d);
            r_f_wave <= w_wave_d[34] ? -35'(w_wave_d[33:0]) : 35'(w_wave_d[33:0]);
            r_f_rmag <= (w_rq_d > RUD_NUM_W'(w_cfg.rudder_rate_limit))
                        ? w_cfg.rudder_rate_limit : 31'(w_rq_d);
            r_f_rneg <= w_sgn_d[0];
            r_f_head <= w_head_d;
        end
    end

    // sum and saturate into the output buffer
    assign w_sum  = r_f_quot + 65'(r_f_wave);
    assign w_rate = r_f_rneg ? -65'(r_f_rmag) : 65'(r_f_rmag);

    always_comb begin
        if (w_sum > SAT_HI) begin
            w_acc_sat = SAT_HI;
        end else if (w_sum < SAT_LO) begin
            w_acc_sat = SAT_LO;
        end else begin
            w_acc_sat = w_sum;
        end
        if (w_rate > SAT_HI) begin
            w_rate_sat = SAT_HI;
        end else if (w_rate < SAT_LO) begin
            w_rate_sat = SAT_LO;
        end else begin
            w_rate_sat = w_rate;
        end
    end

    assign w_out.heading_rate = r_f_head;
    assign w_out.yaw_accel    = w_acc_sat[31:0];
    assign w_out.rudder_rate  = w_rate_sat[31:0];

    // two-entry output buffer
    assign w_push = w_adv && r_vld[LAT_LAST];
    assign w_pop  = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr] <= w_out;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_fifo[r_rd];

endmodule

// File: rtl/core/shpd_chk.sv
// Port-level checker for the plant derivative core, bound to the top level.
module shpd_chk
    import shpd_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    // input side only waits behind a stalled, pending result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled output transfer");

    // reset empties the output buffer
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled output transfer changed or dropped");

endmodule

bind ship_heading_plant_derivatives_core shpd_chk u_shpd_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
